[rtl/fpp_pkg.sv]
// Shared types and constants for the farthest point pair unit.
package fpp_pkg;

   localparam int COORD_BITS = 24;
   localparam int POINT_W    = 3 * COORD_BITS;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int SQ_W       = 2 * COORD_BITS;
   localparam int SUM_W      = 2 * COORD_BITS + 2;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] coord_x;
      logic signed [COORD_BITS-1:0] coord_y;
      logic signed [COORD_BITS-1:0] coord_z;
      logic                         last_point;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] out_x;
      logic signed [COORD_BITS-1:0] out_y;
      logic signed [COORD_BITS-1:0] out_z;
      logic                         second_end;
      logic                         overflowed;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_START,
      ST_ROW,
      ST_PAIR,
      ST_DRAIN,
      ST_RD_A,
      ST_LD_A,
      ST_HOLD_A,
      ST_RD_B,
      ST_LD_B
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic store;        // write the incoming beat into the store
      logic begin_search; // clear the best pair, restart at row zero
      logic row_rd;       // read the row point i
      logic pair_rd;      // read the column point j and advance
      logic emit_rd;      // read an endpoint of the best pair
      logic emit_sel;     // 0: lower-index endpoint, 1: the other
      logic rsp_load;     // capture store read data into the output register
      logic finish;       // clear count and drop flag
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic few_points;
      logic j_end;
      logic i_end;
      logic pipe_empty;
      logic rsp_free;
   } stat_type;

endpackage

[rtl/fpp_ram.sv]
// Generic simple dual-port RAM with registered read.
module fpp_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/fpp_ctrl.sv]
// Sequencer for load, pairwise search and emission of the farthest pair.
module fpp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_last,
   output logic              req_ready,
   output fpp_pkg::cmd_type  cmd,
   input  fpp_pkg::stat_type st
);

   import fpp_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            cmd.store = req_valid;
            if (req_valid && req_last) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.begin_search = 1'b1;
            state_in = st.few_points ? ST_DRAIN : ST_ROW;
         end
         ST_ROW: begin
            cmd.row_rd = 1'b1;
            state_in   = ST_PAIR;
         end
         ST_PAIR: begin
            cmd.pair_rd = 1'b1;
            if (st.j_end) begin
               state_in = st.i_end ? ST_DRAIN : ST_ROW;
            end
         end
         ST_DRAIN: begin
            if (st.pipe_empty && st.rsp_free) begin
               state_in = ST_RD_A;
            end
         end
         ST_RD_A: begin
            cmd.emit_rd = 1'b1;
            state_in    = ST_LD_A;
         end
         ST_LD_A: begin
            cmd.rsp_load = 1'b1;
            state_in     = ST_HOLD_A;
         end
         ST_HOLD_A: begin
            if (st.rsp_free) begin
               state_in = ST_RD_B;
            end
         end
         ST_RD_B: begin
            cmd.emit_rd  = 1'b1;
            cmd.emit_sel = 1'b1;
            state_in     = ST_LD_B;
         end
         ST_LD_B: begin
            cmd.rsp_load = 1'b1;
            cmd.emit_sel = 1'b1;
            cmd.finish   = 1'b1;
            state_in     = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Search and emission never overlap loading.
   a_no_load_in_search: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> !cmd.store)
      else $error("store write outside load");

   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last) |=> (state_ff == ST_START))
      else $error("last point did not start search");

   a_b_follows_a: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD_B) |-> $past(state_ff == ST_HOLD_A))
      else $error("second endpoint read out of order");

endmodule

[rtl/fpp_dp.sv]
// Point store, pairwise distance pipeline, best-pair tracking and output register.
module fpp_dp #(
   parameter int MAX_POINTS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  fpp_pkg::cmd_type  cmd,
   output fpp_pkg::stat_type st,
   input  fpp_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fpp_pkg::rsp_type  rsp_data
);

   import fpp_pkg::*;

   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int CNT_W  = ADDR_W + 1;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              dropped_ff, dropped_in;
   logic [ADDR_W-1:0] i_ff, i_in;
   logic [ADDR_W-1:0] j_ff, j_in;
   logic [ADDR_W-1:0] rd_addr;
   logic [POINT_W-1:0] rd_data;
   logic              full;

   // Pipeline: s1 store data, s2 differences, s3 squares, s4 sum.
   logic              s1_load_ff, s1_pair_ff;
   logic [ADDR_W-1:0] s1_i_ff, s1_j_ff;
   logic              s2_ff, s3_ff, s4_ff;
   logic [ADDR_W-1:0] s2_i_ff, s2_j_ff, s3_i_ff, s3_j_ff, s4_i_ff, s4_j_ff;
   logic [POINT_W-1:0] pi_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, dz_ff;
   logic signed [DIFF_W-1:0] dx_in, dy_in, dz_in;
   logic [SQ_W-1:0]   sqx_ff, sqy_ff, sqz_ff;
   logic signed [2*DIFF_W-1:0] px, py, pz;
   logic [SUM_W-1:0]  sum_ff;

   logic [ADDR_W-1:0] best_i_ff, best_j_ff;
   logic [SUM_W-1:0]  best_d_ff;

   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   assign full = (count_ff >= CNT_W'(MAX_POINTS));

   fpp_ram #(
      .WIDTH (POINT_W),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.store && !full),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({req_data.coord_x, req_data.coord_y, req_data.coord_z}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (cmd.row_rd) begin
         rd_addr = i_ff;
      end else if (cmd.pair_rd) begin
         rd_addr = j_ff;
      end else if (cmd.emit_sel) begin
         rd_addr = best_j_ff;
      end else begin
         rd_addr = best_i_ff;
      end
   end

   // Load counter, drop flag and row/column indexes.
   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      if (cmd.store) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      if (cmd.finish) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end
      if (cmd.begin_search) begin
         i_in = '0;
      end
      if (cmd.row_rd) begin
         j_in = i_ff + ADDR_W'(1);
      end
      if (cmd.pair_rd) begin
         if (st.j_end) begin
            i_in = i_ff + ADDR_W'(1);
         end else begin
            j_in = j_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         i_ff       <= '0;
         j_ff       <= '0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         i_ff       <= i_in;
         j_ff       <= j_in;
      end
   end

   always_comb begin
      st.few_points = (count_ff < CNT_W'(2));
      st.j_end      = ({1'b0, j_ff} == (count_ff - CNT_W'(1)));
      st.i_end      = (({1'b0, i_ff} + CNT_W'(2)) >= count_ff);
      st.pipe_empty = !(s1_load_ff || s1_pair_ff || s2_ff || s3_ff || s4_ff);
      st.rsp_free   = !rsp_valid_ff;
   end

   // Distance pipeline.
   always_comb begin
      dx_in = $signed({rd_data[POINT_W-1], rd_data[POINT_W-1 -: COORD_BITS]})
            - $signed({pi_ff[POINT_W-1], pi_ff[POINT_W-1 -: COORD_BITS]});
      dy_in = $signed({rd_data[2*COORD_BITS-1], rd_data[2*COORD_BITS-1 -: COORD_BITS]})
            - $signed({pi_ff[2*COORD_BITS-1], pi_ff[2*COORD_BITS-1 -: COORD_BITS]});
      dz_in = $signed({rd_data[COORD_BITS-1], rd_data[COORD_BITS-1:0]})
            - $signed({pi_ff[COORD_BITS-1], pi_ff[COORD_BITS-1:0]});
      px = dx_ff * dx_ff;
      py = dy_ff * dy_ff;
      pz = dz_ff * dz_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_load_ff <= 1'b0;
         s1_pair_ff <= 1'b0;
         s2_ff      <= 1'b0;
         s3_ff      <= 1'b0;
         s4_ff      <= 1'b0;
      end else begin
         s1_load_ff <= cmd.row_rd;
         s1_pair_ff <= cmd.pair_rd;
         s2_ff      <= s1_pair_ff;
         s3_ff      <= s2_ff;
         s4_ff      <= s3_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_i_ff <= i_ff;
      s1_j_ff <= j_ff;
      // The row point lands in pi_ff from the store's registered read; earlier pairs still see the old one.
      if (s1_load_ff) begin
         pi_ff <= rd_data;
      end
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      dz_ff   <= dz_in;
      s2_i_ff <= s1_i_ff;
      s2_j_ff <= s1_j_ff;
      sqx_ff  <= px[SQ_W-1:0];
      sqy_ff  <= py[SQ_W-1:0];
      sqz_ff  <= pz[SQ_W-1:0];
      s3_i_ff <= s2_i_ff;
      s3_j_ff <= s2_j_ff;
      sum_ff  <= SUM_W'(sqx_ff) + SUM_W'(sqy_ff) + SUM_W'(sqz_ff);
      s4_i_ff <= s3_i_ff;
      s4_j_ff <= s3_j_ff;
   end

   // Keep the first pair on ties: replace only on strictly greater.
   always_ff @(posedge clock) begin
      if (reset || cmd.begin_search) begin
         best_i_ff <= '0;
         best_j_ff <= '0;
         best_d_ff <= '0;
      end else if (s4_ff && (sum_ff > best_d_ff)) begin
         best_i_ff <= s4_i_ff;
         best_j_ff <= s4_j_ff;
         best_d_ff <= sum_ff;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.out_x      <= rd_data[POINT_W-1 -: COORD_BITS];
         rsp_ff.out_y      <= rd_data[2*COORD_BITS-1 -: COORD_BITS];
         rsp_ff.out_z      <= rd_data[COORD_BITS-1:0];
         rsp_ff.second_end <= cmd.emit_sel;
         rsp_ff.overflowed <= dropped_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_load_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !rsp_valid_ff)
      else $error("output register overwritten");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond store depth");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (best_j_ff != '0) |-> (best_i_ff < best_j_ff))
      else $error("best pair indexes out of order");

   a_emit_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_rd |-> st.pipe_empty)
      else $error("endpoint read while search in flight");

endmodule

[rtl/farthest_point_pair_unit.sv]
// Top level of the farthest point pair unit.
// Points stream in one beat per cycle while loading and are written to a store of
// MAX_POINTS entries; points past that depth are dropped and the overflowed bit is set
// on both results. The beat with last_point set closes the set and starts the search,
// and no new point is taken until the second result has been captured in the output
// register. The search first clears the best pair, then reads the single read port of
// the store once per pair plus once per row, then lets the distance pipeline drain.
// Each endpoint is read from the store and then loaded into the output register; the
// second is read only after the first beat has been taken. The first result is the
// lower-index endpoint (second_end 0), the second the other (second_end 1); ties keep
// the earliest pair, and a set whose points all coincide returns the first point twice.
module farthest_point_pair_unit #(
   parameter int MAX_POINTS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fpp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fpp_pkg::rsp_type rsp_data
);

   import fpp_pkg::*;

   cmd_type  cmd;
   stat_type st;

   fpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_point),
      .req_ready (req_ready),
      .cmd       (cmd),
      .st        (st)
   );

   fpp_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .st        (st),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
